/* rtl/dmac_pkg.sv */
// Package for the four-channel DMA controller.
// Holds widths, register codes, state type and the controller state struct.
// No dependencies.
package dmac_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int CH_W = 2;

   localparam logic [1:0] REQ_NONE  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   localparam logic [3:0] REG_COMMAND  = 4'd8;
   localparam logic [3:0] REG_SOFT_REQ = 4'd9;
   localparam logic [3:0] REG_MASK1    = 4'd10;
   localparam logic [3:0] REG_MODE     = 4'd11;
   localparam logic [3:0] REG_CLR_PTR  = 4'd12;
   localparam logic [3:0] REG_MCLEAR   = 4'd13;
   localparam logic [3:0] REG_CLR_MASK = 4'd14;
   localparam logic [3:0] REG_ALL_MASK = 4'd15;

   localparam logic [1:0] MT_DEMAND = 2'd0;
   localparam logic [1:0] MT_SINGLE = 2'd1;
   localparam logic [1:0] TT_WRITE  = 2'd1;
   localparam logic [1:0] TT_READ   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_BUSREQ, ST_S1, ST_S2, ST_S3, ST_S4, ST_M1, ST_M2, ST_M3, ST_M4
   } xfer_state_type;

   typedef struct packed {
      logic [7:0] data;
      logic       ddrive;
      logic [7:0] addr;
      logic       adrive;
      logic [3:0] dack;
      logic       aen;
      logic       adstb;
      logic [3:0] strobes;
      logic       eop;
   } pins_type;

   typedef struct packed {
      logic [NUM_CHANNELS-1:0] mask;
      logic [NUM_CHANNELS-1:0] soft_req;
      logic [NUM_CHANNELS-1:0] tc_flag;
      logic [7:0]              command;
      logic [7:0]              temp;
      logic                    byte_ptr;
      xfer_state_type          state;
      logic [CH_W-1:0]         act_ch;
      logic                    act_valid;
      logic [7:0]              last_upper;
      logic                    eop_hold;
      logic                    m2m_wr;
      logic                    hrq;
      logic                    last_rst;
      pins_type                pins;
   } ctl_type;

endpackage

/* rtl/dmac_core.sv */
// One DMA clock of the controller: master clear, CPU access, request check,
// transfer step. Holds all controller state. Depends on dmac_pkg.
module dmac_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [1:0]            req_type,
   input  logic [3:0]            reg_addr,
   input  logic [7:0]            wr_data,
   input  logic [3:0]            dreq,
   input  logic                  hlda,
   input  logic                  ready_req,
   input  logic                  bus_busy,
   input  logic [7:0]            bus_data_in,
   input  logic                  reset_in,
   output dmac_pkg::pins_type    pins_out,
   output logic                  hrq_out
);

   localparam int N = dmac_pkg::NUM_CHANNELS;
   localparam int CW = dmac_pkg::CH_W;

   logic [15:0] base_addr_ff  [N];
   logic [15:0] cur_addr_ff   [N];
   logic [15:0] base_count_ff [N];
   logic [15:0] cur_count_ff  [N];
   logic [7:0]  mode_ff       [N];
   logic [15:0] base_addr_in  [N];
   logic [15:0] cur_addr_in   [N];
   logic [15:0] base_count_in [N];
   logic [15:0] cur_count_in  [N];
   logic [7:0]  mode_in       [N];
   dmac_pkg::ctl_type ctl_ff, ctl_in;

   function automatic dmac_pkg::ctl_type clear_ctl(input dmac_pkg::ctl_type c);
      dmac_pkg::ctl_type r;
      r = c;
      r.command = '0; r.temp = '0; r.tc_flag = '0; r.byte_ptr = 1'b0;
      r.state = dmac_pkg::ST_IDLE; r.act_valid = 1'b0; r.act_ch = '0;
      r.last_upper = '0; r.eop_hold = 1'b0; r.m2m_wr = 1'b0;
      r.mask = '1; r.soft_req = '0; r.hrq = 1'b0;
      r.pins.eop = 1'b1; r.pins.dack = 4'hF; r.pins.aen = 1'b0;
      r.pins.adstb = 1'b0; r.pins.strobes = 4'hF;
      r.pins.data = '0; r.pins.ddrive = 1'b0; r.pins.addr = '0; r.pins.adrive = 1'b0;
      return r;
   endfunction

   always_comb begin
      dmac_pkg::ctl_type c;
      logic [CW:0]    ch;
      logic [2:0]     rc;
      logic [CW-1:0]  a;
      logic [15:0]    w;
      logic [15:0]    na;
      logic [1:0]     mt;
      logic [1:0]     tt;
      logic           tc;
      logic           rel;
      logic           done;
      logic           found;
      logic           endsvc;
      logic           aval;
      c = ctl_ff;
      for (int i = 0; i < N; i++) begin
         base_addr_in[i] = base_addr_ff[i]; cur_addr_in[i] = cur_addr_ff[i];
         base_count_in[i] = base_count_ff[i]; cur_count_in[i] = cur_count_ff[i];
         mode_in[i] = mode_ff[i];
      end
      ch = {1'b0, wr_data[1:0]};
      rc = {1'b0, reg_addr[2:1]};
      tc = 1'b0; rel = 1'b0; done = 1'b0; found = 1'b0; endsvc = 1'b0;
      w = '0; na = '0; mt = '0; tt = '0;

      if (reset_in && !ctl_ff.last_rst) c = clear_ctl(c);

      if (req_type == dmac_pkg::REQ_WRITE) begin
         if (!reg_addr[3]) begin
            for (int i = 0; i < N; i++) begin
               if (rc == 3'(i)) begin
                  if (!reg_addr[0]) begin
                     if (!c.byte_ptr) begin
                        base_addr_in[i][7:0] = wr_data; cur_addr_in[i][7:0] = wr_data;
                     end else begin
                        base_addr_in[i][15:8] = wr_data; cur_addr_in[i][15:8] = wr_data;
                     end
                  end else begin
                     if (!c.byte_ptr) begin
                        base_count_in[i][7:0] = wr_data; cur_count_in[i][7:0] = wr_data;
                     end else begin
                        base_count_in[i][15:8] = wr_data; cur_count_in[i][15:8] = wr_data;
                     end
                  end
               end
            end
            c.byte_ptr = !c.byte_ptr;
         end else begin
            unique case (reg_addr)
               dmac_pkg::REG_COMMAND: c.command = wr_data;
               dmac_pkg::REG_SOFT_REQ: begin
                  for (int i = 0; i < N; i++)
                     if (ch == (CW+1)'(i)) c.soft_req[i] = wr_data[2];
               end
               dmac_pkg::REG_MASK1: begin
                  for (int i = 0; i < N; i++)
                     if (ch == (CW+1)'(i)) c.mask[i] = wr_data[2];
               end
               dmac_pkg::REG_MODE: begin
                  for (int i = 0; i < N; i++)
                     if (ch == (CW+1)'(i)) mode_in[i] = wr_data;
               end
               dmac_pkg::REG_CLR_PTR:  c.byte_ptr = 1'b0;
               dmac_pkg::REG_MCLEAR:   c = clear_ctl(c);
               dmac_pkg::REG_CLR_MASK: c.mask = '0;
               default: begin
                  for (int i = 0; i < N; i++)
                     c.mask[i] = (i < 4) ? wr_data[i] : 1'b0;
               end
            endcase
         end
      end else if (req_type == dmac_pkg::REQ_READ) begin
         c.pins.ddrive = 1'b1;
         c.pins.data = 8'hFF;
         if (!reg_addr[3]) begin
            for (int i = 0; i < N; i++) begin
               if (rc == 3'(i)) begin
                  w = reg_addr[0] ? cur_count_ff[i] : cur_addr_ff[i];
                  c.pins.data = c.byte_ptr ? w[15:8] : w[7:0];
               end
            end
            c.byte_ptr = !c.byte_ptr;
         end else if (reg_addr == dmac_pkg::REG_COMMAND) begin
            c.pins.data = {dreq, 4'(c.tc_flag)};
            c.tc_flag = '0;
         end else if (reg_addr == dmac_pkg::REG_MCLEAR) begin
            c.pins.data = c.temp;
         end
      end
      if (req_type != dmac_pkg::REQ_READ) begin
         c.pins.data = '0; c.pins.ddrive = 1'b0;
      end

      if (!c.command[2] && c.state == dmac_pkg::ST_IDLE && !hlda && !bus_busy) begin
         for (int i = 0; i < N; i++) begin
            if (!found && !c.mask[i] && (((i < 4) && dreq[i]) || c.soft_req[i])) begin
               found = 1'b1;
               c.act_ch = CW'(i); c.act_valid = 1'b1;
               c.state = dmac_pkg::ST_BUSREQ; c.hrq = 1'b1;
            end
         end
      end

      a = c.act_ch;
      aval = c.act_valid;
      if (c.eop_hold) begin
         c.pins.eop = 1'b1; c.eop_hold = 1'b0;
      end
      if (c.state != dmac_pkg::ST_IDLE && c.state != dmac_pkg::ST_BUSREQ && !aval) begin
         endsvc = 1'b1;
      end else begin
         if (c.state == dmac_pkg::ST_BUSREQ && hlda) begin
            if (!aval) endsvc = 1'b1;
            else c.state = dmac_pkg::ST_S1;
         end
         unique case (c.state)
            dmac_pkg::ST_S1, dmac_pkg::ST_M1: begin
               if (c.state == dmac_pkg::ST_S1) begin
                  c.pins.aen = 1'b1;
                  if (!c.command[0]) c.pins.dack[a] = 1'b0;
               end
               c.pins.addr = cur_addr_in[a][7:0]; c.pins.adrive = 1'b1;
               c.last_upper = cur_addr_in[a][15:8];
               c.pins.data = cur_addr_in[a][15:8]; c.pins.ddrive = 1'b1;
               c.pins.adstb = 1'b1;
               c.state = (c.state == dmac_pkg::ST_S1) ? dmac_pkg::ST_S2 : dmac_pkg::ST_M2;
            end
            dmac_pkg::ST_S2: begin
               c.pins.adstb = 1'b0;
               tt = mode_in[a][3:2];
               if (c.command[0]) c.pins.strobes[0] = 1'b0;
               else if (tt == dmac_pkg::TT_WRITE) c.pins.strobes[2:1] = 2'b00;
               else if (tt == dmac_pkg::TT_READ) begin
                  c.pins.strobes[0] = 1'b0; c.pins.strobes[3] = 1'b0;
               end
               if (c.command[3]) begin
                  c.pins.data = '0; c.pins.ddrive = 1'b0;
                  c.state = ready_req ? dmac_pkg::ST_S4 : dmac_pkg::ST_S2;
               end else begin
                  c.state = dmac_pkg::ST_S3;
               end
            end
            dmac_pkg::ST_S3: begin
               c.pins.data = '0; c.pins.ddrive = 1'b0;
               if (ready_req) c.state = dmac_pkg::ST_S4;
            end
            dmac_pkg::ST_S4: begin
               c.pins.strobes = 4'hF;
               na = mode_in[a][5] ? cur_addr_in[a] - 16'd1 : cur_addr_in[a] + 16'd1;
               cur_addr_in[a] = na;
               if (c.command[0] && !c.m2m_wr) begin
                  c.temp = bus_data_in;
                  if (c.command[1]) cur_addr_in[a] = base_addr_in[a];
                  c.act_ch = CW'(1); c.m2m_wr = 1'b1; c.state = dmac_pkg::ST_M1;
               end else begin
                  if (cur_count_in[a] == '0) begin
                     tc = 1'b1;
                     c.tc_flag[a] = 1'b1;
                     c.pins.eop = 1'b0; c.eop_hold = 1'b1;
                     if (mode_in[a][4]) begin
                        cur_addr_in[a] = base_addr_in[a];
                        cur_count_in[a] = base_count_in[a];
                     end else begin
                        c.mask[a] = 1'b1;
                     end
                  end else begin
                     cur_count_in[a] = cur_count_in[a] - 16'd1;
                  end
                  if (c.m2m_wr) begin
                     c.m2m_wr = 1'b0;
                     if (tc) endsvc = 1'b1;
                     else begin
                        c.act_ch = '0; c.state = dmac_pkg::ST_S1;
                     end
                  end else begin
                     mt = mode_in[a][7:6];
                     if (mt == dmac_pkg::MT_SINGLE) rel = 1'b1;
                     else if (mt == dmac_pkg::MT_DEMAND) rel = tc || !dreq[a];
                     else rel = tc;
                     if (rel) endsvc = 1'b1;
                     else if (cur_addr_in[a][15:8] != c.last_upper) c.state = dmac_pkg::ST_S1;
                     else begin
                        c.pins.addr = cur_addr_in[a][7:0];
                        c.state = dmac_pkg::ST_S2;
                     end
                  end
               end
            end
            dmac_pkg::ST_M2: begin
               c.pins.adstb = 1'b0;
               c.pins.data = c.temp; c.pins.ddrive = 1'b1;
               c.pins.strobes[1] = 1'b0;
               c.state = c.command[3] ? dmac_pkg::ST_M4 : dmac_pkg::ST_M3;
            end
            dmac_pkg::ST_M3: c.state = dmac_pkg::ST_M4;
            dmac_pkg::ST_M4: begin
               c.pins.strobes[1] = 1'b1;
               c.pins.data = '0; c.pins.ddrive = 1'b0;
               c.state = dmac_pkg::ST_S4;
            end
            default: done = 1'b0;
         endcase
      end

      if (endsvc) begin
         if (c.act_valid) begin
            c.pins.dack[c.act_ch] = 1'b1;
            c.soft_req[c.act_ch] = 1'b0;
         end
         c.hrq = 1'b0; c.pins.aen = 1'b0;
         c.pins.addr = '0; c.pins.adrive = 1'b0;
         c.pins.data = '0; c.pins.ddrive = 1'b0;
         if (c.command[0]) c.soft_req[0] = 1'b0;
         c.state = dmac_pkg::ST_IDLE; c.act_valid = 1'b0; c.act_ch = '0;
         c.m2m_wr = 1'b0;
      end
      if (c.state == dmac_pkg::ST_IDLE || c.state == dmac_pkg::ST_BUSREQ) c.pins.dack = 4'hF;
      c.last_rst = reset_in;
      ctl_in = done ? c : c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= clear_ctl('0);
         for (int i = 0; i < N; i++) begin
            base_addr_ff[i] <= '0; cur_addr_ff[i] <= '0;
            base_count_ff[i] <= '0; cur_count_ff[i] <= '0; mode_ff[i] <= '0;
         end
      end else if (step) begin
         ctl_ff <= ctl_in;
         for (int i = 0; i < N; i++) begin
            base_addr_ff[i] <= base_addr_in[i]; cur_addr_ff[i] <= cur_addr_in[i];
            base_count_ff[i] <= base_count_in[i]; cur_count_ff[i] <= cur_count_in[i];
            mode_ff[i] <= mode_in[i];
         end
      end
   end

   assign pins_out = ctl_in.pins;
   assign hrq_out  = ctl_in.hrq;

   a_idle_no_dack: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff.state == dmac_pkg::ST_IDLE) |-> (ctl_ff.pins.dack == 4'hF))
      else $error("dack asserted while idle");
   a_idle_no_hrq: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff.state == dmac_pkg::ST_IDLE) |-> !ctl_ff.hrq)
      else $error("hrq while idle");
   a_eop_one: assert property (@(posedge clock) disable iff (reset)
      (!ctl_ff.pins.eop) |-> ctl_ff.eop_hold)
      else $error("eop low without hold");

endmodule

/* rtl/four_channel_dma_controller.sv */
// Top level of the four-channel DMA controller.
// dmac_core step logic and state registers, result register. Depends on dmac_pkg, dmac_core.
//
// Usage: each req_ item is one DMA clock: reset_in edge, CPU register access,
// request check and one transfer step, in that order. Each accepted item yields
// exactly one rsp_ item with the pin levels after that clock.
// The result of an item is in the result register the cycle after acceptance.
// One item per cycle is taken while req_stall is low; the step logic sits
// combinationally between the controller state registers.
// The input side keeps accepting while a result waits, as long as the result
// register is free or being taken this cycle; rsp_stall back-pressures req_stall
// only when an unaccepted result is already held.
// reset clears the channel registers to zero, masks all channels, returns the
// transfer machine to idle and empties the result register.
module four_channel_dma_controller (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_req_type,
   input  logic [3:0] req_reg_addr,
   input  logic [7:0] req_wr_data,
   input  logic [3:0] req_dreq,
   input  logic       req_hlda,
   input  logic       req_ready_req,
   input  logic       req_bus_busy,
   input  logic [7:0] req_bus_data_in,
   input  logic       req_reset_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_out,
   output logic       rsp_data_drive,
   output logic [7:0] rsp_addr_low,
   output logic       rsp_addr_drive,
   output logic       rsp_hrq,
   output logic [3:0] rsp_dack_n,
   output logic       rsp_aen,
   output logic       rsp_adstb,
   output logic [3:0] rsp_strobes_n,
   output logic       rsp_eop_n
);

   logic               step;
   logic               out_valid_ff;
   dmac_pkg::pins_type pins, pins_ff;
   logic               hrq, hrq_ff;

   assign req_stall = out_valid_ff && rsp_stall;
   assign step = req_valid && !req_stall;

   dmac_core u_core (
      .clock(clock), .reset(reset), .step(step),
      .req_type(req_req_type), .reg_addr(req_reg_addr), .wr_data(req_wr_data),
      .dreq(req_dreq), .hlda(req_hlda), .ready_req(req_ready_req),
      .bus_busy(req_bus_busy), .bus_data_in(req_bus_data_in),
      .reset_in(req_reset_in), .pins_out(pins), .hrq_out(hrq)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         pins_ff <= pins;
         hrq_ff  <= hrq;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_data_out   = pins_ff.data;
   assign rsp_data_drive = pins_ff.ddrive;
   assign rsp_addr_low   = pins_ff.addr;
   assign rsp_addr_drive = pins_ff.adrive;
   assign rsp_hrq        = hrq_ff;
   assign rsp_dack_n     = pins_ff.dack;
   assign rsp_aen        = pins_ff.aen;
   assign rsp_adstb      = pins_ff.adstb;
   assign rsp_strobes_n  = pins_ff.strobes;
   assign rsp_eop_n      = pins_ff.eop;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(pins_ff)))
      else $error("result changed under stall");
   a_step_gives_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("accepted item lost");
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("stall with empty output");

endmodule
